/* hw/rtl/tksp_pkg.sv */
`timescale 1ns / 1ps
package tksp_pkg;
    localparam int SCORE_W = 32;
    localparam int LIMIT_W = 5;
    localparam logic signed [SCORE_W-1:0] PLUS_INF = 32'sh7FFF_FFFF;

    // configuration register indexes
    localparam logic REG_KEEP   = 1'b0;
    localparam logic REG_MARGIN = 1'b1;

    typedef enum logic [0:0] {
        OP_OFFER  = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PRUNE,
        ST_CUT,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      shift;
        logic                      clear;
        logic                      trunc;
        logic signed [SCORE_W-1:0] cut;
        logic                      do_cut;
    } cell_cmd_t;
endpackage

/* hw/rtl/tksp_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted list. Slot 0 is best. Entries stay sorted by score
// descending, earlier arrival first on ties (a new entry goes after equals).
module tksp_cell
    import tksp_pkg::*;
#(
    parameter int TAG_BITS = 16,
    parameter int IDX_W    = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_cmd_t                 cmd,
    input  logic [IDX_W-1:0]          my_idx,
    input  logic [IDX_W-1:0]          keep_n,
    input  logic signed [SCORE_W-1:0] new_score,
    input  logic [TAG_BITS-1:0]       new_tag,
    input  logic                      up_valid,
    input  logic                      up_goes_after,
    input  logic signed [SCORE_W-1:0] up_score,
    input  logic [TAG_BITS-1:0]       up_tag,
    input  logic                      dn_valid,
    input  logic signed [SCORE_W-1:0] dn_score,
    input  logic [TAG_BITS-1:0]       dn_tag,
    output logic                      valid,
    output logic                      goes_after,
    output logic signed [SCORE_W-1:0] score,
    output logic [TAG_BITS-1:0]       tag
);
    logic                      valid_reg, valid_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [TAG_BITS-1:0]       tag_reg, tag_next;

    // new item lands after this slot
    assign goes_after = valid_reg && (score_reg >= new_score);

    always_comb begin
        valid_next = valid_reg;
        score_next = score_reg;
        tag_next   = tag_reg;
        if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (cmd.ins) begin
            if (!goes_after) begin
                if (up_goes_after || my_idx == '0) begin
                    valid_next = 1'b1;
                    score_next = new_score;
                    tag_next   = new_tag;
                end else begin
                    valid_next = up_valid;
                    score_next = up_score;
                    tag_next   = up_tag;
                end
            end
        end else if (cmd.trunc) begin
            if (my_idx >= keep_n) valid_next = 1'b0;
        end else if (cmd.do_cut) begin
            if (valid_reg && score_reg < cmd.cut) valid_next = 1'b0;
        end else if (cmd.shift) begin
            valid_next = dn_valid;
            score_next = dn_score;
            tag_next   = dn_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign tag   = tag_reg;
endmodule

/* hw/rtl/top_k_score_pruning_list_top.sv */
`timescale 1ns / 1ps
// Best-k candidate list. Entries live sorted in a chain of 2*MAX_KEEP+1 cells,
// each new offer shifting into place in the insert step, so an offer runs as
// accept, insert; an offer that overflows twice the limit adds a prune step.
// A finish runs as accept, prune, cut, then one result beat per survivor,
// since survivors shift out of the head cell one per beat; when the margin
// drops every entry the empty beat comes from a separate empty state, and a
// stalled beat holds the chain. The next item is accepted only after the
// last beat of a finish has left the output register.
module top_k_score_pruning_list_top
    import tksp_pkg::*;
#(
    parameter int MAX_KEEP = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [((SCORE_W+TAG_BITS+7)/8)*8-1:0] s_tdata, // score, tag
    input  logic                s_tuser,  // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((TAG_BITS+SCORE_W+7)/8)*8-1:0] m_tdata, // out_tag, out_score
    output logic                m_tuser,  // valid_res
    output logic                m_tlast
);
    localparam int DEPTH = 2 * MAX_KEEP + 1;
    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((TAG_BITS + SCORE_W + 7) / 8) * 8;

    logic [LIMIT_W-1:0]        keep_limit_reg;
    logic signed [SCORE_W-1:0] beam_margin_reg;
    logic signed [SCORE_W-1:0] thr_reg, thr_next;
    logic [IDX_W-1:0]          count_reg, count_next;
    logic signed [SCORE_W-1:0] in_score_reg;
    logic [TAG_BITS-1:0]       in_tag_reg;
    logic                      in_op_reg;
    state_t                    state_reg, state_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_user_reg, m_user_next;
    logic [OUT_W-1:0]          m_data_reg, m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_limit_reg  <= LIMIT_W'(16);
            beam_margin_reg <= 32'sh8000_0000;
        end else if (cfg_we) begin
            if (cfg_index == REG_KEEP) keep_limit_reg <= cfg_data[LIMIT_W-1:0];
            else                       beam_margin_reg <= cfg_data;
        end
    end

    logic [IDX_W-1:0] lim;
    always_comb begin
        if (keep_limit_reg == '0)                      lim = IDX_W'(1);
        else if (32'(keep_limit_reg) > MAX_KEEP)       lim = IDX_W'(MAX_KEEP);
        else                                           lim = IDX_W'(keep_limit_reg);
    end

    cell_cmd_t                 cmd;
    logic [DEPTH:0]            c_valid;
    logic [DEPTH-1:0]          c_after;
    logic signed [SCORE_W-1:0] c_score [DEPTH+1];
    logic [TAG_BITS-1:0]       c_tag [DEPTH+1];

    assign c_valid[DEPTH] = 1'b0;
    assign c_score[DEPTH] = '0;
    assign c_tag[DEPTH]   = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            tksp_cell #(.TAG_BITS(TAG_BITS), .IDX_W(IDX_W)) u_cell (
                .aclk, .aresetn, .cmd,
                .my_idx(IDX_W'(g)), .keep_n(lim),
                .new_score(in_score_reg), .new_tag(in_tag_reg),
                .up_valid(c_valid[(g == 0) ? 0 : g-1]),
                .up_goes_after(c_after[(g == 0) ? 0 : g-1] && (g != 0)),
                .up_score(c_score[(g == 0) ? 0 : g-1]),
                .up_tag(c_tag[(g == 0) ? 0 : g-1]),
                .dn_valid(c_valid[g+1]), .dn_score(c_score[g+1]), .dn_tag(c_tag[g+1]),
                .valid(c_valid[g]), .goes_after(c_after[g]),
                .score(c_score[g]), .tag(c_tag[g])
            );
        end
    endgenerate

    logic        take;
    logic signed [SCORE_W-1:0] lim_score;  // best dropped on prune = slot lim
    logic signed [SCORE_W:0]   cut_wide;
    assign take      = (count_reg < lim) || (in_score_reg > thr_reg);
    assign lim_score = c_score[lim[IDX_W-1:0]];
    assign cut_wide  = (SCORE_W+1)'(c_score[0]) + (SCORE_W+1)'(beam_margin_reg);

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        thr_next     = thr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        cmd          = '0;
        cmd.cut      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready)
                    state_next = (s_tuser == OP_FINISH) ? ST_PRUNE : ST_INSERT;
            end
            ST_INSERT: begin
                if (count_reg < lim && in_score_reg < thr_reg) thr_next = in_score_reg;
                if (take && count_reg < IDX_W'(DEPTH)) begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_IDLE;
                if ((take && count_reg < IDX_W'(DEPTH) ? count_reg + 1'b1 : count_reg)
                        > (lim << 1))
                    state_next = ST_PRUNE;
            end
            ST_PRUNE: begin
                if (count_reg > lim) begin
                    cmd.trunc  = 1'b1;
                    count_next = lim;
                    if (!in_op_reg && lim_score > thr_reg) thr_next = lim_score;
                end
                state_next = in_op_reg ? ST_CUT : ST_IDLE;
            end
            ST_CUT: begin
                if (count_reg == '0) begin
                    state_next = ST_EMPTY;
                end else begin
                    cmd.do_cut = 1'b1;
                    // best+margin below the score range drops nothing
                    if (cut_wide[SCORE_W] != cut_wide[SCORE_W-1])
                        cmd.cut = {1'b1, {(SCORE_W-1){1'b0}}};
                    else
                        cmd.cut = cut_wide[SCORE_W-1:0];
                    // a positive margin puts best+margin above every entry, even past the range
                    if (cut_wide > (SCORE_W+1)'(c_score[0])) cmd.clear = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    if (!c_valid[0]) begin
                        state_next = ST_EMPTY;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = OUT_W'({c_score[0], c_tag[0]});
                        m_user_next  = 1'b1;
                        m_last_next  = !c_valid[1];
                        cmd.shift    = 1'b1;
                        if (!c_valid[1]) begin
                            cmd.clear  = 1'b1;
                            count_next = '0;
                            thr_next   = PLUS_INF;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMPTY: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = 1'b0;
                    m_last_next  = 1'b1;
                    cmd.clear    = 1'b1;
                    count_next   = '0;
                    thr_next     = PLUS_INF;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            thr_reg     <= PLUS_INF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
        if (s_tvalid && s_tready) begin
            in_score_reg <= s_tdata[SCORE_W-1:0];
            in_tag_reg   <= s_tdata[SCORE_W +: TAG_BITS];
            in_op_reg    <= s_tuser;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= IDX_W'(DEPTH)) else $error("count overflow");
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && state_reg == ST_IDLE) |-> c_valid[0])
        else $error("head cell empty with nonzero count");
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && state_reg == ST_IDLE) |-> count_reg == '0)
        else $error("list not cleared after finish");
endmodule
